@@ design/i2c_mra_pkg.sv @@
package i2c_mra_pkg;

	// stream widths, fields packed from the lowest bit up, padded to whole bytes
	localparam int S_DATA_W = 32;
	localparam int M_DATA_W = 16;
	localparam int M_USED_W = 13;

	// ticks per bus phase after reset
	localparam logic [7:0] TPP_RESET = 8'd1;

	// direction bit appended to the device address
	localparam logic DIR_WRITE = 1'b0;
	localparam logic DIR_READ  = 1'b1;

	// bus sequence segments, each made of up to four phases
	typedef enum logic [13:0] {
		SEG_IDLE   = 14'b00000000000001,
		SEG_START  = 14'b00000000000010,
		SEG_TXA    = 14'b00000000000100,
		SEG_ACKA   = 14'b00000000001000,
		SEG_TXR    = 14'b00000000010000,
		SEG_ACKR   = 14'b00000000100000,
		SEG_TXD    = 14'b00000001000000,
		SEG_ACKD   = 14'b00000010000000,
		SEG_STOP   = 14'b00000100000000,
		SEG_RSTART = 14'b00001000000000,
		SEG_TXAR   = 14'b00010000000000,
		SEG_ACKAR  = 14'b00100000000000,
		SEG_RX     = 14'b01000000000000,
		SEG_NACK   = 14'b10000000000000
	} seg_t;

endpackage

@@ design/i2c_master_register_access.sv @@
// An item's result is registered and offered on the master side, going through the skid
// entry first when the output register still holds an earlier result.
// Throughput: one item per cycle while the skid entry is empty; the bus state update is a single pass of shallow logic.
// A two-entry output buffer keeps the slave side open while one result waits.
// Reset (arst_n low, asynchronous): sequencer idle, both lines released, ticks per phase 1.
module i2c_master_register_access (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [7:0]                        cfg_wdata,  // ticks_per_phase
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// is_read[0], device_address[7:1], reg_addr[15:8], write_data[23:16], sda_in[24]
	input  logic [i2c_mra_pkg::S_DATA_W-1:0]  s_tdata,
	input  logic                              s_tuser,    // req_type
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// scl_out[0], sda_out[1], busy_res[2], done_res[3], success[4], read_data[12:5]
	output logic [i2c_mra_pkg::M_DATA_W-1:0]  m_tdata
);
	import i2c_mra_pkg::*;

	// configuration and sequencer state
	logic [7:0] tpp_q;
	seg_t       seg_q;
	logic [1:0] sub_q;
	logic [7:0] phase_q;
	logic [3:0] bitcnt_q;
	logic [7:0] shift_q;
	logic       lat_read_q;
	logic [6:0] lat_dev_q;
	logic [7:0] lat_reg_q;
	logic [7:0] lat_data_q;
	logic       lat_ok_q;
	logic       scl_q;
	logic       sda_q;

	// output buffer
	logic                out_valid_q;
	logic [M_DATA_W-1:0] out_data_q;
	logic                skid_valid_q;
	logic [M_DATA_W-1:0] skid_data_q;

	// input fields
	logic       in_read;
	logic [6:0] in_dev;
	logic [7:0] in_reg;
	logic [7:0] in_data;
	logic       in_sda;

	// next state and result
	seg_t       seg_d;
	logic [1:0] sub_d;
	logic [7:0] phase_d;
	logic [3:0] bitcnt_d;
	logic [7:0] shift_d;
	logic       lat_read_d;
	logic [6:0] lat_dev_d;
	logic [7:0] lat_reg_d;
	logic [7:0] lat_data_d;
	logic       lat_ok_d;
	logic       scl_d;
	logic       sda_d;
	logic       go;
	logic       go_begin;
	seg_t       go_seg;
	logic [1:0] go_sub;
	logic       fin;
	logic       busy;
	logic       done;
	logic       ok_r;
	logic [7:0] data_r;
	logic [7:0] len;
	logic [M_DATA_W-1:0] res;

	logic acc;
	logic pop;

	assign in_read = s_tdata[0];
	assign in_dev  = s_tdata[7:1];
	assign in_reg  = s_tdata[15:8];
	assign in_data = s_tdata[23:16];
	assign in_sda  = s_tdata[24];

	assign s_tready = !skid_valid_q;
	assign acc      = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign pop      = out_valid_q && m_tready;

	// phase length, zero acts as one
	assign len = (tpp_q == 8'd0) ? 8'd1 : tpp_q;

	// one bus step per item
	always_comb begin
		seg_d      = seg_q;
		sub_d      = sub_q;
		phase_d    = phase_q;
		bitcnt_d   = bitcnt_q;
		shift_d    = shift_q;
		lat_read_d = lat_read_q;
		lat_dev_d  = lat_dev_q;
		lat_reg_d  = lat_reg_q;
		lat_data_d = lat_data_q;
		lat_ok_d   = lat_ok_q;
		scl_d      = scl_q;
		sda_d      = sda_q;
		go         = 1'b0;
		go_begin   = 1'b0;
		go_seg     = seg_q;
		go_sub     = 2'd0;
		fin        = 1'b0;
		busy       = 1'b0;
		done       = 1'b0;
		ok_r       = 1'b0;
		data_r     = 8'd0;

		// decide the next phase
		if (s_tuser) begin
			busy = 1'b1;
			if (seg_q == SEG_IDLE) begin
				lat_read_d = in_read;
				lat_dev_d  = in_dev;
				lat_reg_d  = in_reg;
				lat_data_d = in_data;
				lat_ok_d   = 1'b0;
				go         = 1'b1;
				go_begin   = 1'b1;
				go_seg     = SEG_START;
			end
		end else if (seg_q != SEG_IDLE) begin
			busy    = 1'b1;
			phase_d = phase_q + 8'd1;
			if (phase_d >= len) begin
				case (seg_q)
					SEG_START, SEG_RSTART: begin
						// bus busy or bus error only checked on the first start
						if (seg_q == SEG_START && sub_q == 2'd0 && !in_sda) begin
							fin = 1'b1;
						end else if (seg_q == SEG_START && sub_q == 2'd1 && in_sda) begin
							fin = 1'b1;
						end else if (sub_q < 2'd2) begin
							go     = 1'b1;
							go_sub = sub_q + 2'd1;
						end else if (sub_q == 2'd2) begin
							go       = 1'b1;
							go_begin = 1'b1;
							go_seg   = (seg_q == SEG_START) ? SEG_TXA : SEG_TXAR;
						end else begin
							fin = 1'b1;
						end
					end
					SEG_TXA, SEG_TXR, SEG_TXD, SEG_TXAR: begin
						if (sub_q < 2'd2) begin
							go     = 1'b1;
							go_sub = sub_q + 2'd1;
						end else if (sub_q == 2'd2) begin
							bitcnt_d = bitcnt_q + 4'd1;
							go       = 1'b1;
							if (bitcnt_d[3]) begin
								go_begin = 1'b1;
								case (seg_q)
									SEG_TXA: go_seg = SEG_ACKA;
									SEG_TXR: go_seg = SEG_ACKR;
									SEG_TXD: go_seg = SEG_ACKD;
									default: go_seg = SEG_ACKAR;
								endcase
							end
						end else begin
							fin = 1'b1;
						end
					end
					SEG_ACKA, SEG_ACKR, SEG_ACKD, SEG_ACKAR: begin
						go = 1'b1;
						if (sub_q < 2'd3) begin
							// only the first address ack is checked
							if (seg_q == SEG_ACKA && sub_q == 2'd2) begin
								lat_ok_d = !in_sda;
							end
							go_sub = sub_q + 2'd1;
						end else begin
							go_begin = 1'b1;
							case (seg_q)
								SEG_ACKA: go_seg = lat_ok_q ? SEG_TXR : SEG_STOP;
								SEG_ACKR: go_seg = lat_read_q ? SEG_RSTART : SEG_TXD;
								SEG_ACKD: go_seg = SEG_STOP;
								default:  go_seg = SEG_RX;
							endcase
						end
					end
					SEG_RX: begin
						if (sub_q == 2'd0) begin
							go     = 1'b1;
							go_sub = 2'd1;
						end else if (sub_q == 2'd1) begin
							shift_d  = {shift_q[6:0], in_sda};
							bitcnt_d = bitcnt_q + 4'd1;
							go       = 1'b1;
							if (bitcnt_d[3]) begin
								go_begin = 1'b1;
								go_seg   = SEG_NACK;
							end
						end else begin
							fin = 1'b1;
						end
					end
					SEG_NACK: begin
						go = 1'b1;
						if (sub_q < 2'd3) begin
							go_sub = sub_q + 2'd1;
						end else begin
							go_begin = 1'b1;
							go_seg   = SEG_STOP;
						end
					end
					SEG_STOP: begin
						if (sub_q < 2'd3) begin
							go     = 1'b1;
							go_sub = sub_q + 2'd1;
						end else begin
							fin = 1'b1;
						end
					end
					default: begin
						fin = 1'b1;
					end
				endcase
			end
		end

		// segment start: reset bit count, load the byte (for a receive: clear it and release the data line)
		if (go && go_begin) begin
			bitcnt_d = 4'd0;
			case (go_seg)
				SEG_TXA:  shift_d = {lat_dev_d, DIR_WRITE};
				SEG_TXAR: shift_d = {lat_dev_d, DIR_READ};
				SEG_TXR:  shift_d = lat_reg_d;
				SEG_TXD:  shift_d = lat_data_d;
				SEG_RX: begin
					shift_d = 8'd0;
					sda_d   = 1'b1;
				end
				default: ;
			endcase
		end

		// phase entry: set the line drives
		if (go) begin
			seg_d   = go_seg;
			sub_d   = go_sub;
			phase_d = 8'd0;
			case (go_seg)
				SEG_START, SEG_RSTART: begin
					if (go_sub == 2'd0) begin
						sda_d = 1'b1;
						scl_d = 1'b1;
					end else begin
						sda_d = 1'b0;
					end
				end
				SEG_TXA, SEG_TXR, SEG_TXD, SEG_TXAR: begin
					if (go_sub == 2'd0) begin
						scl_d = 1'b0;
					end else if (go_sub == 2'd1) begin
						sda_d   = shift_d[7];
						shift_d = {shift_d[6:0], 1'b0};
					end else begin
						scl_d = 1'b1;
					end
				end
				SEG_ACKA, SEG_ACKR, SEG_ACKD, SEG_ACKAR, SEG_NACK: begin
					if (go_sub == 2'd1) begin
						sda_d = 1'b1;
					end else begin
						scl_d = (go_sub == 2'd2);
					end
				end
				SEG_RX: begin
					scl_d = (go_sub == 2'd1);
				end
				SEG_STOP: begin
					case (go_sub)
						2'd0:    scl_d = 1'b0;
						2'd1:    sda_d = 1'b0;
						2'd2:    scl_d = 1'b1;
						default: sda_d = 1'b1;
					endcase
				end
				default: ;
			endcase
		end

		// transaction finished
		if (fin) begin
			ok_r    = lat_ok_d;
			data_r  = (lat_ok_d && lat_read_d) ? shift_d : 8'd0;
			seg_d   = SEG_IDLE;
			sub_d   = 2'd0;
			phase_d = 8'd0;
			busy    = 1'b0;
			done    = 1'b1;
		end
	end

	assign res = {{(M_DATA_W - M_USED_W){1'b0}}, data_r, ok_r, done, busy, sda_d, scl_d};

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tpp_q <= TPP_RESET;
		end else if (cfg_we) begin
			tpp_q <= cfg_wdata;
		end
	end

	// sequencer state, updated per accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_q      <= SEG_IDLE;
			sub_q      <= 2'd0;
			phase_q    <= 8'd0;
			bitcnt_q   <= 4'd0;
			shift_q    <= 8'd0;
			lat_read_q <= 1'b0;
			lat_dev_q  <= 7'd0;
			lat_reg_q  <= 8'd0;
			lat_data_q <= 8'd0;
			lat_ok_q   <= 1'b0;
			scl_q      <= 1'b1;
			sda_q      <= 1'b1;
		end else if (acc) begin
			seg_q      <= seg_d;
			sub_q      <= sub_d;
			phase_q    <= phase_d;
			bitcnt_q   <= bitcnt_d;
			shift_q    <= shift_d;
			lat_read_q <= lat_read_d;
			lat_dev_q  <= lat_dev_d;
			lat_reg_q  <= lat_reg_d;
			lat_data_q <= lat_data_d;
			lat_ok_q   <= lat_ok_d;
			scl_q      <= scl_d;
			sda_q      <= sda_d;
		end
	end

	// output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (!out_valid_q || pop) begin
			if (skid_valid_q) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= acc;
			end
		end else if (acc) begin
			skid_valid_q <= 1'b1;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (!out_valid_q || pop) begin
			out_data_q <= skid_valid_q ? skid_data_q : res;
		end else if (acc) begin
			skid_data_q <= res;
		end
	end

	// skid entry only fills behind a waiting result
	a_skid_order: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with empty output register");

	// a finishing result never reports busy
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_data_q[3]) |-> !out_data_q[2])
		else $error("done result reports busy");

	// success and read data only come with done
	a_success_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_data_q[3]) |-> (!out_data_q[4] && out_data_q[12:5] == 8'd0))
		else $error("success or read data without done");

	// idle sequencer keeps a cleared phase counter
	a_idle_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(seg_q == SEG_IDLE) |-> (phase_q == 8'd0 && sub_q == 2'd0))
		else $error("idle sequencer with phase state");

endmodule

@@ sim/i2c_master_register_access_tb.sv @@
module i2c_master_register_access_tb;

	import i2c_mra_pkg::*;

	localparam int CYCLE_LIMIT = 500000;

	// result fields, scl_out in the lowest bit as on m_tdata
	typedef struct packed {
		logic [7:0] data;
		logic       ok;
		logic       done;
		logic       busy;
		logic       sda;
		logic       scl;
	} bus_result_t;

	// how the simulated bus answers the checks of one transfer
	typedef enum {FAULT_NONE, FAULT_BUSY, FAULT_ERROR, FAULT_NACK} fault_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [7:0]          cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	// is_read, device_address, reg_addr, write_data, sda_in
	logic [S_DATA_W-1:0] s_tdata;
	logic                s_tuser;    // req_type
	logic                m_tvalid;
	logic                m_tready;
	// scl_out, sda_out, busy_res, done_res, success, read_data
	logic [M_DATA_W-1:0] m_tdata;

	i2c_master_register_access DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// bus sequencer mirror
	seg_t        seg_q = SEG_IDLE;
	logic [1:0]  sub_q = 2'd0;
	logic [7:0]  tick_cnt = 8'd0;
	logic [7:0]  phase_len = TPP_RESET;
	logic [3:0]  bit_cnt = 4'd0;
	logic [7:0]  shreg = 8'd0;
	logic        lat_read = 1'b0;
	logic [6:0]  lat_dev = 7'd0;
	logic [7:0]  lat_reg = 8'd0;
	logic [7:0]  lat_wdata = 8'd0;
	logic        lat_ack = 1'b0;
	logic        scl_drv = 1'b1;
	logic        sda_drv = 1'b1;

	bus_result_t expected_results[$];
	int          mismatch_count = 0;
	int          bus_items = 0;
	int          send_gap_pct = 21;
	int          recv_gap_pct = 81;
	int          hold_cycles = 0;

	// pin update at the start of a phase
	function automatic void enter_phase(seg_t seg, logic [1:0] sub);
		seg_q = seg;
		sub_q = sub;
		tick_cnt = 8'd0;
		case (seg)
			SEG_START, SEG_RSTART: begin
				if (sub == 2'd0) begin
					sda_drv = 1'b1;
					scl_drv = 1'b1;
				end else
					sda_drv = 1'b0;
			end
			SEG_TXA, SEG_TXR, SEG_TXD, SEG_TXAR: begin
				if (sub == 2'd0)
					scl_drv = 1'b0;
				else if (sub == 2'd1) begin
					sda_drv = shreg[7];
					shreg = {shreg[6:0], 1'b0};
				end else
					scl_drv = 1'b1;
			end
			SEG_ACKA, SEG_ACKR, SEG_ACKD, SEG_ACKAR, SEG_NACK: begin
				if (sub == 2'd1)
					sda_drv = 1'b1;
				else
					scl_drv = (sub == 2'd2);
			end
			SEG_RX:
				scl_drv = (sub == 2'd1);
			SEG_STOP: begin
				case (sub)
					2'd0: scl_drv = 1'b0;
					2'd1: sda_drv = 1'b0;
					2'd2: scl_drv = 1'b1;
					default: sda_drv = 1'b1;
				endcase
			end
			default: ;
		endcase
	endfunction

	// load the shift byte for a segment, then enter its first phase
	function automatic void begin_seg(seg_t seg);
		bit_cnt = 4'd0;
		case (seg)
			SEG_TXA: shreg = {lat_dev, DIR_WRITE};
			SEG_TXAR: shreg = {lat_dev, DIR_READ};
			SEG_TXR: shreg = lat_reg;
			SEG_TXD: shreg = lat_wdata;
			SEG_RX: begin
				shreg = 8'd0;
				sda_drv = 1'b1;
			end
			default: ;
		endcase
		enter_phase(seg, 2'd0);
	endfunction

	// phase end with the sampled line; returns 1 when the transfer is over
	function automatic bit end_phase(logic s);
		case (seg_q)
			SEG_START, SEG_RSTART: begin
				// bus busy: line low although released
				if (seg_q == SEG_START && sub_q == 2'd0 && !s)
					return 1'b1;
				// bus error: line high although driven low
				if (seg_q == SEG_START && sub_q == 2'd1 && s)
					return 1'b1;
				if (sub_q < 2'd2)
					enter_phase(seg_q, sub_q + 2'd1);
				else if (sub_q == 2'd2)
					begin_seg(seg_q == SEG_START ? SEG_TXA : SEG_TXAR);
				else
					return 1'b1;
			end
			SEG_TXA, SEG_TXR, SEG_TXD, SEG_TXAR: begin
				if (sub_q < 2'd2)
					enter_phase(seg_q, sub_q + 2'd1);
				else if (sub_q != 2'd2)
					return 1'b1;
				else begin
					bit_cnt = bit_cnt + 4'd1;
					// the ack segment follows each transmit segment
					if (bit_cnt < 4'd8)
						enter_phase(seg_q, 2'd0);
					else
						begin_seg(seg_t'(seg_q << 1));
				end
			end
			SEG_ACKA, SEG_ACKR, SEG_ACKD, SEG_ACKAR: begin
				if (sub_q < 2'd3) begin
					// only the first address ack counts
					if (seg_q == SEG_ACKA && sub_q == 2'd2)
						lat_ack = !s;
					enter_phase(seg_q, sub_q + 2'd1);
				end else begin
					case (seg_q)
						SEG_ACKA: begin_seg(lat_ack ? SEG_TXR : SEG_STOP);
						SEG_ACKR: begin_seg(lat_read ? SEG_RSTART : SEG_TXD);
						SEG_ACKD: begin_seg(SEG_STOP);
						default: begin_seg(SEG_RX);
					endcase
				end
			end
			SEG_RX: begin
				if (sub_q == 2'd0)
					enter_phase(seg_q, 2'd1);
				else if (sub_q != 2'd1)
					return 1'b1;
				else begin
					shreg = {shreg[6:0], s};
					bit_cnt = bit_cnt + 4'd1;
					if (bit_cnt < 4'd8)
						enter_phase(seg_q, 2'd0);
					else
						begin_seg(SEG_NACK);
				end
			end
			SEG_NACK: begin
				if (sub_q < 2'd3)
					enter_phase(seg_q, sub_q + 2'd1);
				else
					begin_seg(SEG_STOP);
			end
			SEG_STOP: begin
				if (sub_q < 2'd3)
					enter_phase(seg_q, sub_q + 2'd1);
				else
					return 1'b1;
			end
			default:
				return 1'b1;
		endcase
		return 1'b0;
	endfunction

	// expected result of one accepted item, advancing the mirror
	function automatic bus_result_t predict_item(logic req, logic rd, logic [6:0] dev,
			logic [7:0] ra, logic [7:0] wd, logic s);
		bus_result_t r;
		r = '0;
		if (req) begin
			// a request while busy is dropped
			if (seg_q == SEG_IDLE) begin
				lat_read = rd;
				lat_dev = dev;
				lat_reg = ra;
				lat_wdata = wd;
				lat_ack = 1'b0;
				begin_seg(SEG_START);
			end
			r.busy = 1'b1;
		end else if (seg_q != SEG_IDLE) begin
			r.busy = 1'b1;
			tick_cnt = tick_cnt + 8'd1;
			// zero phase length behaves as one
			if (tick_cnt >= (phase_len == 8'd0 ? 8'd1 : phase_len)) begin
				if (end_phase(s)) begin
					r.ok = lat_ack;
					r.data = (lat_ack && lat_read) ? shreg : 8'd0;
					seg_q = SEG_IDLE;
					sub_q = 2'd0;
					tick_cnt = 8'd0;
					r.busy = 1'b0;
					r.done = 1'b1;
				end
			end
		end
		r.scl = scl_drv;
		r.sda = sda_drv;
		return r;
	endfunction

	// line level the bus shows for the next tick
	function automatic logic line_level(fault_t f);
		logic phase_end;
		phase_end = (tick_cnt + 8'd1) >= (phase_len == 8'd0 ? 8'd1 : phase_len);
		if (phase_end && seg_q == SEG_START && sub_q == 2'd0)
			return f != FAULT_BUSY;
		if (phase_end && seg_q == SEG_START && sub_q == 2'd1)
			return f == FAULT_ERROR;
		if (phase_end && seg_q == SEG_ACKA && sub_q == 2'd2)
			return f == FAULT_NACK;
		return 1'($urandom_range(1));
	endfunction

	function automatic void compare_field(string name, int want, int got);
		if (want != got) begin
			$display("%0t: %s expected %0d actual %0d", $time, name, want, got);
			mismatch_count++;
		end
	endfunction

	// offer one item, starting and ending at a falling edge
	task automatic send_item(input logic req, input logic rd, input logic [6:0] dev,
			input logic [7:0] ra, input logic [7:0] wd, input logic s);
		bus_result_t r;
		if ($urandom_range(99) < send_gap_pct) begin
			s_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser <= req;
		s_tdata <= {7'd0, s, wd, ra, dev, rd};
		do @(posedge clk); while (!s_tready);
		r = predict_item(req, rd, dev, ra, wd, s);
		expected_results.push_back(r);
		@(negedge clk);
	endtask

	// one request, then ticks, mixed with dropped repeat requests at retry_pct, until the transfer finishes
	task automatic run_transfer(input logic rd, input logic [6:0] dev, input logic [7:0] ra,
			input logic [7:0] wd, input fault_t f, input int retry_pct);
		send_item(1'b1, rd, dev, ra, wd, 1'($urandom_range(1)));
		bus_items++;
		while (seg_q != SEG_IDLE) begin
			if ($urandom_range(99) < retry_pct)
				send_item(1'b1, 1'($urandom_range(1)), 7'($urandom_range(127)),
					8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)));
			else begin
				send_item(1'b0, 1'($urandom_range(1)), 7'($urandom_range(127)),
					8'($urandom_range(255)), 8'($urandom_range(255)), line_level(f));
				bus_items++;
			end
		end
	endtask

	task automatic random_transfer();
		fault_t f;
		int pick;
		pick = $urandom_range(99);
		f = pick < 70 ? FAULT_NONE : pick < 80 ? FAULT_BUSY : pick < 90 ? FAULT_ERROR : FAULT_NACK;
		run_transfer(1'($urandom_range(1)), 7'($urandom_range(127)), 8'($urandom_range(255)),
			8'($urandom_range(255)), f, 3);
		// a few ticks on the idle bus
		repeat ($urandom_range(2))
			send_item(1'b0, 1'($urandom_range(1)), 7'($urandom_range(127)),
				8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)));
	endtask

	// phase length is changed only with the bus idle and every result drained
	task automatic set_phase_len(input logic [7:0] len);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= len;
		@(negedge clk);
		cfg_we <= 1'b0;
		phase_len = len;
	endtask

	task automatic test_idle_and_faults();
		// ticks on an idle bus
		send_item(1'b0, 1'b0, 7'h00, 8'h00, 8'h00, 1'b0);
		send_item(1'b0, 1'b1, 7'h7F, 8'hFF, 8'hFF, 1'b1);
		// bus busy at start, with a second request arriving during the check
		send_item(1'b1, 1'b1, 7'h7F, 8'hFF, 8'hFF, 1'b0);
		send_item(1'b1, 1'b0, 7'h00, 8'h00, 8'h00, 1'b1);
		send_item(1'b0, 1'b0, 7'h00, 8'h00, 8'h00, 1'b0);
		// bus error at start
		send_item(1'b1, 1'b0, 7'h00, 8'h00, 8'h00, 1'b0);
		send_item(1'b0, 1'b1, 7'h55, 8'hAA, 8'h55, 1'b1);
		send_item(1'b0, 1'b0, 7'h2A, 8'h55, 8'hAA, 1'b1);
		// address nack, then a write and a read at the field extremes
		run_transfer(1'b0, 7'h7F, 8'hFF, 8'h00, FAULT_NACK, 0);
		run_transfer(1'b0, 7'h00, 8'h00, 8'hFF, FAULT_NONE, 0);
		run_transfer(1'b1, 7'h7F, 8'hFF, 8'h00, FAULT_NONE, 0);
	endtask

	task automatic test_phase_length_extremes();
		set_phase_len(8'd0);
		run_transfer(1'b0, 7'h2A, 8'h81, 8'h3C, FAULT_NONE, 0);
		run_transfer(1'b1, 7'h15, 8'h7E, 8'hC3, FAULT_BUSY, 0);
		set_phase_len(8'd255);
		run_transfer(1'b1, 7'h40, 8'h01, 8'h80, FAULT_BUSY, 1);
		run_transfer(1'b0, 7'h01, 8'h80, 8'h01, FAULT_ERROR, 1);
		set_phase_len(8'd1);
	endtask

	task automatic test_random_traffic(input int sgap, input int rgap, input int quota);
		int first;
		int pick;
		logic [7:0] len;
		send_gap_pct = sgap;
		recv_gap_pct = rgap;
		first = bus_items;
		while (bus_items - first < quota) begin
			if ($urandom_range(3) == 0) begin
				// mostly short phases, now and then a zero length
				pick = $urandom_range(19);
				len = pick < 10 ? 8'd1 : pick < 17 ? 8'($urandom_range(3, 2)) :
					pick < 19 ? 8'($urandom_range(6, 4)) : 8'd0;
				set_phase_len(len);
			end
			random_transfer();
		end
	endtask

	// receiver stalls long enough for the output buffer to fill
	task automatic test_output_backpressure();
		send_gap_pct = 0;
		hold_cycles = 200;
		run_transfer(1'b1, 7'($urandom_range(127)), 8'($urandom_range(255)),
			8'($urandom_range(255)), FAULT_NONE, 0);
		run_transfer(1'b0, 7'($urandom_range(127)), 8'($urandom_range(255)),
			8'($urandom_range(255)), FAULT_NONE, 0);
	endtask

	// result side ready, with a long hold when asked
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				m_tready <= 1'b0;
				repeat (hold_cycles - 1) @(negedge clk);
				hold_cycles = 0;
			end else
				m_tready <= ($urandom_range(99) >= recv_gap_pct);
		end
	end

	// compare each result item against the oldest expectation
	always @(posedge clk) begin : check_results
		bus_result_t got;
		bus_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = bus_result_t'(m_tdata[12:0]);
			if (expected_results.size() == 0) begin
				$display("%0t: result none expected actual %h", $time, m_tdata);
				mismatch_count++;
			end else begin
				want = expected_results.pop_front();
				compare_field("scl_out", want.scl, got.scl);
				compare_field("sda_out", want.sda, got.sda);
				compare_field("busy_res", want.busy, got.busy);
				compare_field("done_res", want.done, got.done);
				compare_field("success", want.ok, got.ok);
				compare_field("read_data", want.data, got.data);
			end
		end
	end

	// watchdog
	initial begin : watchdog
		int n;
		for (n = 0; n < CYCLE_LIMIT; n++)
			@(posedge clk);
		$display("Mismatches found");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = 1'b0;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_and_faults();
		test_phase_length_extremes();
		test_random_traffic(21, 81, 60);
		test_random_traffic(81, 21, 60);
		test_random_traffic(0, 0, 60);
		test_output_backpressure();

		// drain, then allow the output stage to settle
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (5) @(negedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
